// ===== rtl/core/ole_pkg.sv =====
// Package: shared constants, opcodes, status codes and controller/datapath interface types.
`timescale 1ns / 1ps
package ole_pkg;
    localparam int DEPTH = 32;
    localparam int IW = $clog2(DEPTH);
    localparam int LW = IW + 1;
    localparam logic [LW-1:0] NUL = LW'(DEPTH);

    typedef enum logic [2:0] {
        OP_INS = 3'd0,
        OP_DELK = 3'd1,
        OP_DELF = 3'd2,
        OP_DELL = 3'd3,
        OP_DUMP = 3'd4
    } op_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic load;
        logic insert;
        logic fetch;
        logic advance;
        logic unlink_tail;
        logic unlink_cur;
        logic unlink_fix;
        logic emit;
        logic emit_key;
        logic [1:0] status;
        logic last;
    } ole_cmd_t;

    typedef struct packed {
        logic full;
        logic cur_nul;
        logic match;
        logic next_nul;
        logic steps_done;
    } ole_sts_t;
endpackage

// ===== rtl/core/ole_datapath.sv =====
// Datapath: node store memories, head/tail/free stack registers and the list walk.
`timescale 1ns / 1ps
module ole_datapath
    import ole_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ole_cmd_t           cmd,
    input  logic signed [31:0] key,
    output ole_sts_t           sts,
    output logic signed [31:0] out_key,
    output logic [1:0]         status,
    output logic               last,
    output logic               valid
);
    logic [31:0]   key_mem [DEPTH];
    logic [LW-1:0] nxt_mem [DEPTH];
    logic [LW-1:0] prv_mem [DEPTH];
    logic [IW-1:0] free_mem [DEPTH];

    logic [LW-1:0] head_reg, tail_reg, free_top_reg, cur_reg, steps_reg;
    logic [LW-1:0] free_init_reg;
    logic [31:0]   key_reg, rd_key_reg;
    logic [LW-1:0] rd_nxt_reg, rd_prv_reg;
    logic          fix_nxt_reg, fix_prv_reg;
    logic [LW-1:0] fix_p_reg, fix_n_reg;
    logic signed [31:0] out_key_reg;
    logic [1:0]    status_reg;
    logic          last_reg, valid_reg;
    logic [IW-1:0] slot_reg;

    assign sts.full = (free_top_reg == '0);
    assign sts.cur_nul = (cur_reg == NUL);
    assign sts.match = (rd_key_reg == key_reg);
    assign sts.next_nul = (rd_nxt_reg == NUL);
    assign sts.steps_done = (steps_reg + 1'b1 >= LW'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            key_mem[slot_reg] <= key_reg;
            prv_mem[slot_reg] <= NUL;
            nxt_mem[slot_reg] <= head_reg;
            if (head_reg != NUL)
            begin
                prv_mem[IW'(head_reg)] <= LW'(slot_reg);
            end
        end
        if (cmd.fetch && cur_reg != NUL)
        begin
            rd_key_reg <= key_mem[IW'(cur_reg)];
            rd_nxt_reg <= nxt_mem[IW'(cur_reg)];
            rd_prv_reg <= prv_mem[IW'(cur_reg)];
        end
        if (cmd.unlink_fix)
        begin
            if (fix_nxt_reg)
            begin
                nxt_mem[IW'(fix_p_reg)] <= fix_n_reg;
            end
            if (fix_prv_reg)
            begin
                prv_mem[IW'(fix_n_reg)] <= fix_p_reg;
            end
            free_mem[IW'(free_top_reg)] <= IW'(cur_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= NUL;
            tail_reg <= NUL;
            free_top_reg <= LW'(DEPTH);
            free_init_reg <= LW'(DEPTH);
            cur_reg <= NUL;
            steps_reg <= '0;
            valid_reg <= 1'b0;
            fix_nxt_reg <= 1'b0;
            fix_prv_reg <= 1'b0;
            fix_p_reg <= NUL;
            fix_n_reg <= NUL;
        end
        else
        begin
            valid_reg <= cmd.emit;
            if (cmd.load)
            begin
                cur_reg <= cmd.unlink_tail ? tail_reg : head_reg;
                steps_reg <= '0;
            end
            if (cmd.advance)
            begin
                cur_reg <= rd_nxt_reg;
                steps_reg <= steps_reg + 1'b1;
            end
            if (cmd.insert)
            begin
                if (head_reg == NUL)
                begin
                    tail_reg <= LW'(slot_reg);
                end
                head_reg <= LW'(slot_reg);
                free_top_reg <= free_top_reg - 1'b1;
                if (free_top_reg <= free_init_reg)
                begin
                    free_init_reg <= free_top_reg - 1'b1;
                end
            end
            if (cmd.unlink_cur)
            begin
                fix_p_reg <= rd_prv_reg;
                fix_n_reg <= rd_nxt_reg;
                fix_nxt_reg <= (rd_prv_reg != NUL);
                fix_prv_reg <= (rd_nxt_reg != NUL);
                if (rd_prv_reg == NUL)
                begin
                    head_reg <= rd_nxt_reg;
                end
                if (rd_nxt_reg == NUL)
                begin
                    tail_reg <= rd_prv_reg;
                end
            end
            if (cmd.unlink_fix)
            begin
                free_top_reg <= free_top_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= key;
            // free stack reads as identity until a slot is pushed above the initial fill
            slot_reg <= (free_top_reg > free_init_reg) ? free_mem[IW'(free_top_reg - 1'b1)]
                                                       : IW'(free_top_reg - 1'b1);
        end
        if (cmd.emit)
        begin
            out_key_reg <= cmd.emit_key ? rd_key_reg : '0;
            status_reg <= cmd.status;
            last_reg <= cmd.last;
        end
    end

    assign out_key = out_key_reg;
    assign status = status_reg;
    assign last = last_reg;
    assign valid = valid_reg;
endmodule

// ===== rtl/core/ole_ctrl.sv =====
// Controller: state machine sequencing each request over the datapath.
`timescale 1ns / 1ps
module ole_ctrl
    import ole_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic [2:0] op,
    input  ole_sts_t sts,
    output ole_cmd_t cmd,
    output logic     busy
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_CHECK = 6'b000100,
        S_FIX   = 6'b001000,
        S_WAIT  = 6'b010000,
        S_DUMP  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_INS;
        end
        else
        begin
            state_reg <= state_next;
            if (start && state_reg == S_IDLE)
            begin
                op_reg <= op;
            end
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    cmd.unlink_tail = (op == OP_DELL);
                    unique case (op)
                        OP_INS:
                        begin
                            state_next = S_FIX;
                        end
                        OP_DELK, OP_DELF, OP_DELL, OP_DUMP:
                        begin
                            state_next = S_FETCH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                cmd.fetch = 1'b1;
                if (sts.cur_nul)
                begin
                    cmd.emit = 1'b1;
                    cmd.status = ST_MISS;
                    cmd.last = 1'b1;
                    state_next = S_WAIT;
                end
                else
                begin
                    state_next = (op_reg == OP_DUMP) ? S_DUMP : S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (op_reg != OP_DELK || sts.match)
                begin
                    cmd.unlink_cur = 1'b1;
                    state_next = S_FIX;
                end
                else if (sts.next_nul || sts.steps_done)
                begin
                    cmd.emit = 1'b1;
                    cmd.status = ST_MISS;
                    cmd.last = 1'b1;
                    state_next = S_WAIT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FIX:
            begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                if (op_reg == OP_INS)
                begin
                    cmd.insert = !sts.full;
                    cmd.status = sts.full ? ST_FULL : ST_OK;
                end
                else
                begin
                    cmd.unlink_fix = 1'b1;
                    cmd.status = ST_OK;
                end
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            S_DUMP:
            begin
                cmd.emit = 1'b1;
                cmd.emit_key = 1'b1;
                cmd.status = ST_OK;
                cmd.last = sts.next_nul || sts.steps_done;
                if (cmd.last)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next = S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/core/ordered_list_engine.sv =====
// Top level: bounded doubly linked list engine with command-style handshake.
// Insert goes from idle straight to the fix state; delete first/last also pass through fetch and check.
// Delete by key: a fetch and a check state per node visited, for at most DEPTH nodes.
// Dump: a fetch and a dump state per node, one result strobe per node and one store read per node.
// Asynchronous active-low reset empties the list and marks every slot free.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module ordered_list_engine
    import ole_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         op,
    input  logic signed [31:0] key,
    output logic               valid,
    output logic signed [31:0] out_key,
    output logic [1:0]         status,
    output logic               last
);
    ole_cmd_t cmd;
    ole_sts_t sts;

    ole_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    ole_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .key     (key),
        .sts     (sts),
        .out_key (out_key),
        .status  (status),
        .last    (last),
        .valid   (valid)
    );

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> busy)
        else $error("result raised while idle");
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last) |-> busy)
        else $error("request ended without final transfer");
    a_full_key: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && status != ST_OK) |-> (out_key == 32'sd0 && last))
        else $error("flagged result malformed");
endmodule

// ===== tb/ordered_list_engine_tb.sv =====
// Testbench for ordered_list_engine: random and directed list requests checked against a predictor.
`timescale 1ns / 1ps
module ordered_list_engine_tb
    import ole_pkg::*;
();
    typedef struct packed {
        logic signed [31:0] out_key;
        logic [1:0]         status;
        logic               last;
    } list_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         op = 3'd0;
    logic signed [31:0] key = '0;
    logic               busy;
    logic               valid;
    logic signed [31:0] out_key;
    logic [1:0]         status;
    logic               last;

    logic signed [31:0] list_keys[$];
    list_result_t       pending_results[$];
    int                 error_count = 0;
    int                 cycle_count = 0;

    ordered_list_engine i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .op      (op),
        .key     (key),
        .valid   (valid),
        .out_key (out_key),
        .status  (status),
        .last    (last)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("[ordered_list_engine] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        list_result_t exp_r;
        if (rst_n && valid)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result");
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_key !== exp_r.out_key)
                    report_mismatch($sformatf("out_key %0d exp %0d", out_key, exp_r.out_key));
                if (status !== exp_r.status)
                    report_mismatch($sformatf("status %0d exp %0d", status, exp_r.status));
                if (last !== exp_r.last)
                    report_mismatch($sformatf("last %0d exp %0d", last, exp_r.last));
            end
        end
    end

    function automatic list_result_t mk(input logic signed [31:0] k, input logic [1:0] s,
                                        input logic l);
        list_result_t r;
        r.out_key = k;
        r.status = s;
        r.last = l;
        return r;
    endfunction

    // front of list is index 0
    task automatic predict_request(input logic [2:0] o, input logic signed [31:0] k);
        int idx;
        idx = -1;
        case (o)
            OP_INS:
                if (list_keys.size() >= DEPTH)
                    pending_results.push_back(mk(0, ST_FULL, 1'b1));
                else
                begin
                    list_keys.push_front(k);
                    pending_results.push_back(mk(0, ST_OK, 1'b1));
                end
            OP_DELK:
            begin
                for (int i = 0; i < list_keys.size(); i++)
                    if (idx < 0 && list_keys[i] == k)
                        idx = i;
                if (idx < 0)
                    pending_results.push_back(mk(0, ST_MISS, 1'b1));
                else
                begin
                    list_keys.delete(idx);
                    pending_results.push_back(mk(0, ST_OK, 1'b1));
                end
            end
            OP_DELF, OP_DELL:
                if (list_keys.size() == 0)
                    pending_results.push_back(mk(0, ST_MISS, 1'b1));
                else
                begin
                    if (o == OP_DELF)
                        void'(list_keys.pop_front());
                    else
                        void'(list_keys.pop_back());
                    pending_results.push_back(mk(0, ST_OK, 1'b1));
                end
            OP_DUMP:
                if (list_keys.size() == 0)
                    pending_results.push_back(mk(0, ST_MISS, 1'b1));
                else
                    foreach (list_keys[i])
                        pending_results.push_back(mk(list_keys[i], ST_OK,
                                                     i == list_keys.size() - 1));
            default: ;
        endcase
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        repeat (n) @(posedge clk);
    endtask

    task automatic send_request(input logic [2:0] o, input logic signed [31:0] k,
                                input bit gaps = 1'b1);
        if (gaps)
            idle_gap();
        start <= 1'b1;
        op <= o;
        key <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(o, k);
        start <= 1'b0;
        op <= 3'($urandom);
        key <= $urandom;
        @(posedge clk);
    endtask

    task automatic test_directed();
        send_request(OP_DUMP, 0);
        send_request(OP_DELF, 0);
        send_request(OP_DELL, 0);
        send_request(OP_DELK, 5);
        send_request(OP_INS, 32'sh7fffffff);
        send_request(OP_INS, 32'sh80000000);
        send_request(OP_INS, -1);
        send_request(OP_INS, 0);
        send_request(OP_INS, -1);
        send_request(OP_DUMP, 0);
        send_request(OP_DELK, -1);
        send_request(OP_DELK, 1234);
        send_request(3'd5, 0);
        send_request(3'd6, 0);
        send_request(3'd7, -1);
        send_request(OP_DELF, 0);
        send_request(OP_DELL, 0);
        send_request(OP_DUMP, 0);
    endtask

    task automatic test_full_list();
        for (int i = 0; i < DEPTH + 2; i++)
            send_request(OP_INS, i * 3 - 40, i > 20);
        send_request(OP_DUMP, 0);
        send_request(OP_DELK, -40);
        send_request(OP_DELK, 53);
        send_request(OP_DUMP, 0);
        while (list_keys.size() > 0)
            send_request($urandom_range(0, 1) ? OP_DELF : OP_DELL, 0, 1'b0);
    endtask

    task automatic test_random();
        logic [2:0]         o;
        logic signed [31:0] k;
        int                 r;
        for (int n = 0; n < 240; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                o = OP_INS;
            else if (r < 60)
                o = OP_DELK;
            else if (r < 72)
                o = OP_DELF;
            else if (r < 84)
                o = OP_DELL;
            else if (r < 97)
                o = OP_DUMP;
            else
                o = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 3) == 0)
                k = $urandom;
            else if (o == OP_DELK && list_keys.size() > 0 && $urandom_range(0, 2) != 0)
                k = list_keys[$urandom_range(0, list_keys.size() - 1)];
            else
                k = $signed(32'($urandom_range(0, 15))) - 8;
            send_request(o, k, n % 64 < 48);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_list();
        test_random();
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("[ordered_list_engine] OK");
        else
            $display("[ordered_list_engine] ERROR");
        $finish;
    end
endmodule
